// ===== rtl/hbrk_pkg.sv =====
// ----------------------------------------------------------------------------
// hbrk_pkg
// Shared types and constants for the four-channel H-bridge driver with
// soft stop and kick start.
// ----------------------------------------------------------------------------
package hbrk_pkg;

  // channel count and field widths
  localparam int unsigned NUM_CH     = 4;
  localparam int unsigned SPEED_W    = 9;
  localparam int unsigned DUTY_W     = 8;
  localparam int unsigned DIR_W      = 2;
  localparam int unsigned TICK_W     = 10;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 10;

  typedef logic signed [SPEED_W-1:0] speed_t;

  // command codes
  typedef enum logic [1:0] {
    OP_SET  = 2'd0,
    OP_STOP = 2'd1,
    OP_KICK = 2'd2,
    OP_TICK = 2'd3
  } op_e;

  // controller state
  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_RAMP = 2'd1,
    MODE_KICK = 2'd2
  } mode_e;

  // bridge direction codes
  localparam logic [DIR_W-1:0] DIR_OFF = 2'd0;
  localparam logic [DIR_W-1:0] DIR_FWD = 2'd1;
  localparam logic [DIR_W-1:0] DIR_REV = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_STEP     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_INTERVAL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KICK_DUTY     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KICK_TIME     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT_MASK   = 3'd4;

  // configuration register file
  typedef struct packed {
    logic [7:0]        ramp_step;
    logic [TICK_W-1:0] ramp_interval;
    logic [7:0]        kick_duty;
    logic [TICK_W-1:0] kick_time;
    logic [NUM_CH-1:0] invert_mask;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    ramp_step:     8'd10,
    ramp_interval: 10'd20,
    kick_duty:     8'd200,
    kick_time:     10'd100,
    invert_mask:   4'hf
  };

endpackage

// ===== rtl/hbrk_if.sv =====
// ----------------------------------------------------------------------------
// hbrk_cmd_if / hbrk_res_if
// Valid/ready channels for commands into and drive results out of the core.
// ----------------------------------------------------------------------------

// command channel
interface hbrk_cmd_if;
  logic                 valid;
  logic                 ready;
  logic [1:0]           operation;
  hbrk_pkg::speed_t     front_left_speed;
  hbrk_pkg::speed_t     front_right_speed;
  hbrk_pkg::speed_t     back_left_speed;
  hbrk_pkg::speed_t     back_right_speed;

  modport source (
    output valid, operation, front_left_speed, front_right_speed,
           back_left_speed, back_right_speed,
    input  ready
  );
  modport sink (
    input  valid, operation, front_left_speed, front_right_speed,
           back_left_speed, back_right_speed,
    output ready
  );
endinterface

// result channel
interface hbrk_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] front_left_dir;
  logic [1:0] front_right_dir;
  logic [1:0] back_left_dir;
  logic [1:0] back_right_dir;
  logic [7:0] front_left_duty;
  logic [7:0] front_right_duty;
  logic [7:0] back_left_duty;
  logic [7:0] back_right_duty;
  logic       busy_res;

  modport source (
    output valid, front_left_dir, front_right_dir, back_left_dir, back_right_dir,
           front_left_duty, front_right_duty, back_left_duty, back_right_duty,
           busy_res,
    input  ready
  );
  modport sink (
    input  valid, front_left_dir, front_right_dir, back_left_dir, back_right_dir,
           front_left_duty, front_right_duty, back_left_duty, back_right_duty,
           busy_res,
    output ready
  );
endinterface

// ===== rtl/hbrk_state.sv =====
// ----------------------------------------------------------------------------
// hbrk_state
// Speed state and ramp/kick controller: applies one command per enable.
// ----------------------------------------------------------------------------
module hbrk_state (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  hbrk_pkg::op_e         op_i,
  input  hbrk_pkg::speed_t      tgt_i     [hbrk_pkg::NUM_CH],
  input  hbrk_pkg::cfg_t        cfg_i,
  output hbrk_pkg::speed_t      applied_o [hbrk_pkg::NUM_CH],
  output logic                  busy_o
);

  hbrk_pkg::mode_e                  mode_q, mode_d;
  logic [hbrk_pkg::TICK_W-1:0]      cnt_q, cnt_d, cnt_inc;
  logic [hbrk_pkg::TICK_W-1:0]      interval;
  logic [7:0]                       step;
  hbrk_pkg::speed_t                 app_q  [hbrk_pkg::NUM_CH];
  hbrk_pkg::speed_t                 app_d  [hbrk_pkg::NUM_CH];
  hbrk_pkg::speed_t                 pend_q [hbrk_pkg::NUM_CH];
  hbrk_pkg::speed_t                 pend_d [hbrk_pkg::NUM_CH];
  hbrk_pkg::speed_t                 ramped [hbrk_pkg::NUM_CH];
  hbrk_pkg::speed_t                 kicked [hbrk_pkg::NUM_CH];
  hbrk_pkg::speed_t                 kick_pos;
  logic                             any_moving;
  logic                             ramp_done;

  // move one speed toward zero by the step, clamping at zero
  function automatic hbrk_pkg::speed_t toward_zero(hbrk_pkg::speed_t v, logic [7:0] s);
    logic signed [9:0] vx;
    logic signed [9:0] sx;
    logic signed [9:0] r;
    vx = 10'(v);
    sx = $signed({2'b00, s});
    r  = '0;
    if (vx > sx) begin
      r = vx - sx;
    end else if (vx < -sx) begin
      r = vx + sx;
    end
    return r[8:0];
  endfunction

  // step and interval of zero behave as one
  assign step     = (cfg_i.ramp_step == '0) ? 8'd1 : cfg_i.ramp_step;
  assign interval = (cfg_i.ramp_interval == '0) ? 10'd1 : cfg_i.ramp_interval;
  assign cnt_inc  = cnt_q + 10'd1;
  assign kick_pos = $signed({1'b0, cfg_i.kick_duty});

  // per-channel ramp step and kick speed
  always_comb begin
    any_moving = 1'b0;
    ramp_done  = 1'b1;
    for (int i = 0; i < hbrk_pkg::NUM_CH; i++) begin
      ramped[i] = toward_zero(app_q[i], step);
      if (app_q[i] != '0) any_moving = 1'b1;
      if (ramped[i] != '0) ramp_done = 1'b0;
      if (tgt_i[i] > 0) begin
        kicked[i] = kick_pos;
      end else if (tgt_i[i] < 0) begin
        kicked[i] = -kick_pos;
      end else begin
        kicked[i] = '0;
      end
    end
  end

  // next state
  always_comb begin
    mode_d = mode_q;
    cnt_d  = cnt_q;
    app_d  = app_q;
    pend_d = pend_q;
    if (en_i) begin
      unique case (op_i)
        hbrk_pkg::OP_SET: begin
          app_d  = tgt_i;
          mode_d = hbrk_pkg::MODE_IDLE;
          cnt_d  = '0;
        end
        hbrk_pkg::OP_STOP: begin
          cnt_d  = '0;
          mode_d = hbrk_pkg::MODE_IDLE;
          if (any_moving) begin
            app_d = ramped;
            if (!ramp_done) mode_d = hbrk_pkg::MODE_RAMP;
          end
        end
        hbrk_pkg::OP_KICK: begin
          cnt_d = '0;
          if (cfg_i.kick_time == '0) begin
            app_d  = tgt_i;
            mode_d = hbrk_pkg::MODE_IDLE;
          end else begin
            pend_d = tgt_i;
            app_d  = kicked;
            mode_d = hbrk_pkg::MODE_KICK;
          end
        end
        hbrk_pkg::OP_TICK: begin
          unique case (mode_q)
            hbrk_pkg::MODE_RAMP: begin
              cnt_d = cnt_inc;
              if (cnt_inc >= interval) begin
                cnt_d = '0;
                app_d = ramped;
                if (ramp_done) mode_d = hbrk_pkg::MODE_IDLE;
              end
            end
            hbrk_pkg::MODE_KICK: begin
              cnt_d = cnt_inc;
              if (cnt_inc >= cfg_i.kick_time) begin
                cnt_d  = '0;
                app_d  = pend_q;
                mode_d = hbrk_pkg::MODE_IDLE;
              end
            end
            hbrk_pkg::MODE_IDLE: begin
              mode_d = hbrk_pkg::MODE_IDLE;
            end
            default: begin
              mode_d = hbrk_pkg::MODE_IDLE;
            end
          endcase
        end
        default: begin
          mode_d = mode_q;
        end
      endcase
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= hbrk_pkg::MODE_IDLE;
      cnt_q  <= '0;
      for (int i = 0; i < hbrk_pkg::NUM_CH; i++) begin
        app_q[i]  <= '0;
        pend_q[i] <= '0;
      end
    end else begin
      mode_q <= mode_d;
      cnt_q  <= cnt_d;
      app_q  <= app_d;
      pend_q <= pend_d;
    end
  end

  assign applied_o = app_d;
  assign busy_o    = (mode_d != hbrk_pkg::MODE_IDLE);

endmodule

// ===== rtl/hbrk_drive.sv =====
// ----------------------------------------------------------------------------
// hbrk_drive
// Turns one signed channel speed into a bridge direction code and a duty.
// ----------------------------------------------------------------------------
module hbrk_drive #(
  parameter int unsigned DUTY_MAX = 255
) (
  input  hbrk_pkg::speed_t                   speed_i,
  input  logic                               invert_i,
  output logic [hbrk_pkg::DIR_W-1:0]         dir_o,
  output logic [hbrk_pkg::DUTY_W-1:0]        duty_o
);

  // effective limit is the smaller of the parameter and the duty range
  localparam int unsigned SAT     = (DUTY_MAX > 255) ? 255 : DUTY_MAX;
  localparam logic [8:0]  SAT_LIM = 9'(SAT);

  logic signed [9:0] sx;
  logic signed [9:0] mag_w;
  logic [8:0]        mag;

  // magnitude in 10 bits so that -256 stays exact
  assign sx    = 10'(speed_i);
  assign mag_w = sx[9] ? -sx : sx;
  assign mag   = mag_w[8:0];

  // direction after inversion, then saturated duty
  always_comb begin
    if (speed_i == '0) begin
      dir_o = hbrk_pkg::DIR_OFF;
    end else if (speed_i[8] ^ invert_i) begin
      dir_o = hbrk_pkg::DIR_REV;
    end else begin
      dir_o = hbrk_pkg::DIR_FWD;
    end
    duty_o = (mag > SAT_LIM) ? SAT_LIM[7:0] : mag[7:0];
  end

endmodule

// ===== rtl/four_motor_hbridge_ramp_kick_core.sv =====
// ----------------------------------------------------------------------------
// four_motor_hbridge_ramp_kick_core
// Four-channel H-bridge driver with soft-stop ramp and kick start.
// ----------------------------------------------------------------------------
// Every command transaction (set, soft stop, kick, tick) yields exactly one
// result transaction with the direction code and duty of all four channels
// and a busy flag. The core takes one transaction per clock cycle; a result
// passes one input register, then the speed update and drive encoding in a
// single pass into the result register, and back-pressure on the result side
// stalls the command side only when both registers are full. Configuration
// writes take effect on the next edge and are meant to be made while no
// transaction is in flight.
// ----------------------------------------------------------------------------
module four_motor_hbridge_ramp_kick_core #(
  parameter int unsigned DUTY_MAX = 255
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  hbrk_cmd_if.sink                            cmd_i,
  hbrk_res_if.source                          res_o,
  input  logic                                cfg_we_i,
  input  logic [hbrk_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [hbrk_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  hbrk_pkg::cfg_t                    cfg_q;
  logic                              in_valid_q;
  hbrk_pkg::op_e                     op_q;
  hbrk_pkg::speed_t                  tgt_q   [hbrk_pkg::NUM_CH];
  hbrk_pkg::speed_t                  applied [hbrk_pkg::NUM_CH];
  logic                              busy;
  logic                              adv;
  logic                              upd;
  logic [hbrk_pkg::DIR_W-1:0]        dir_c   [hbrk_pkg::NUM_CH];
  logic [hbrk_pkg::DUTY_W-1:0]       duty_c  [hbrk_pkg::NUM_CH];
  logic                              res_valid_q;
  logic [hbrk_pkg::DIR_W-1:0]        dir_q   [hbrk_pkg::NUM_CH];
  logic [hbrk_pkg::DUTY_W-1:0]       duty_q  [hbrk_pkg::NUM_CH];
  logic                              busy_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= hbrk_pkg::CFG_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        hbrk_pkg::REG_RAMP_STEP:     cfg_q.ramp_step     <= cfg_data_i[7:0];
        hbrk_pkg::REG_RAMP_INTERVAL: cfg_q.ramp_interval <= cfg_data_i;
        hbrk_pkg::REG_KICK_DUTY:     cfg_q.kick_duty     <= cfg_data_i[7:0];
        hbrk_pkg::REG_KICK_TIME:     cfg_q.kick_time     <= cfg_data_i;
        hbrk_pkg::REG_INVERT_MASK:   cfg_q.invert_mask   <= cfg_data_i[3:0];
        default: begin
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

  // pipeline handshake
  assign adv         = !res_valid_q || res_o.ready;
  assign upd         = in_valid_q && adv;
  assign cmd_i.ready = !in_valid_q || adv;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (cmd_i.ready) begin
      in_valid_q <= cmd_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.valid && cmd_i.ready) begin
      op_q     <= hbrk_pkg::op_e'(cmd_i.operation);
      tgt_q[0] <= cmd_i.front_left_speed;
      tgt_q[1] <= cmd_i.front_right_speed;
      tgt_q[2] <= cmd_i.back_left_speed;
      tgt_q[3] <= cmd_i.back_right_speed;
    end
  end

  // speed state and ramp/kick control
  hbrk_state u_state (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (upd),
    .op_i      (op_q),
    .tgt_i     (tgt_q),
    .cfg_i     (cfg_q),
    .applied_o (applied),
    .busy_o    (busy)
  );

  // per-channel drive encoding
  for (genvar g = 0; g < hbrk_pkg::NUM_CH; g++) begin : g_drive
    hbrk_drive #(
      .DUTY_MAX (DUTY_MAX)
    ) u_drive (
      .speed_i  (applied[g]),
      .invert_i (cfg_q.invert_mask[g]),
      .dir_o    (dir_c[g]),
      .duty_o   (duty_c[g])
    );
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (adv) begin
      res_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd) begin
      dir_q  <= dir_c;
      duty_q <= duty_c;
      busy_q <= busy;
    end
  end

  assign res_o.valid            = res_valid_q;
  assign res_o.front_left_dir   = dir_q[0];
  assign res_o.front_right_dir  = dir_q[1];
  assign res_o.back_left_dir    = dir_q[2];
  assign res_o.back_right_dir   = dir_q[3];
  assign res_o.front_left_duty  = duty_q[0];
  assign res_o.front_right_duty = duty_q[1];
  assign res_o.back_left_duty   = duty_q[2];
  assign res_o.back_right_duty  = duty_q[3];
  assign res_o.busy_res         = busy_q;

endmodule

// ===== tb/sv/four_motor_hbridge_ramp_kick_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_motor_hbridge_ramp_kick_core_tb
// Self-checking bench for the four-channel H-bridge core. A script of
// directed commands covers reset, speed extremes, inversion, soft stop, kick
// and their interactions. Randomized set/stop/kick/tick traffic follows under
// several register settings. Every drive result is compared against a local
// speed model or a scripted expectation, with random gaps on both channels.
// ----------------------------------------------------------------------------
module four_motor_hbridge_ramp_kick_core_tb;

  localparam int DUTY_LIMIT     = 255;
  localparam int SETTLE_CYCLES  = 4;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int NUM_PHASES     = 8;
  localparam int PHASE_ITEMS    = 35;
  localparam int LONG_TICKS     = 16;

  // direction and duty of all four channels plus the busy flag
  typedef struct packed {
    logic [hbrk_pkg::NUM_CH-1:0][hbrk_pkg::DIR_W-1:0]  dir;
    logic [hbrk_pkg::NUM_CH-1:0][hbrk_pkg::DUTY_W-1:0] duty;
    logic                                              busy;
  } drive_t;

  // one line of the directed script: a register write or a command
  typedef struct {
    bit                               is_cfg;
    logic [hbrk_pkg::CFG_IDX_W-1:0]   reg_idx;
    logic [hbrk_pkg::CFG_DATA_W-1:0]  reg_val;
    hbrk_pkg::op_e                    op;
    hbrk_pkg::speed_t                 sp [hbrk_pkg::NUM_CH];
    bit                               typed;
    drive_t                           want;
  } script_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic                            cfg_we_i;
  logic [hbrk_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [hbrk_pkg::CFG_DATA_W-1:0] cfg_data_i;

  hbrk_cmd_if cmd_bus ();
  hbrk_res_if res_bus ();

  four_motor_hbridge_ramp_kick_core #(
    .DUTY_MAX (DUTY_LIMIT)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd_bus),
    .res_o      (res_bus),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  // model state
  hbrk_pkg::cfg_t    cfg_shadow = hbrk_pkg::CFG_RESET;
  hbrk_pkg::speed_t  motor_speed [hbrk_pkg::NUM_CH];
  hbrk_pkg::speed_t  held_target [hbrk_pkg::NUM_CH];
  hbrk_pkg::mode_e   ctrl_mode = hbrk_pkg::MODE_IDLE;
  logic [hbrk_pkg::TICK_W-1:0] tick_count = '0;

  drive_t      pending_drive [$];
  int unsigned items_sent   = 0;
  int unsigned fail_count   = 0;
  int unsigned quiet_cycles = 0;
  int unsigned sink_hold    = 0;
  bit          src_idle_en  = 1'b1;
  bit          sink_idle_en = 1'b1;

  initial begin
    foreach (motor_speed[ch]) begin
      motor_speed[ch] = '0;
      held_target[ch] = '0;
    end
  end

  // one soft-stop step on every channel, true when all reach zero
  function automatic bit ramp_all();
    int step;
    int v;
    bit all_zero;
    step = (cfg_shadow.ramp_step == 8'd0) ? 1 : int'(cfg_shadow.ramp_step);
    all_zero = 1'b1;
    for (int ch = 0; ch < hbrk_pkg::NUM_CH; ch++) begin
      v = motor_speed[ch];
      if (v > 0) v = (v > step) ? v - step : 0;
      else if (v < 0) v = (v < -step) ? v + step : 0;
      motor_speed[ch] = hbrk_pkg::speed_t'(v);
      if (v != 0) all_zero = 1'b0;
    end
    return all_zero;
  endfunction

  // advance the speed model by one command and encode the bridge drive
  function automatic drive_t predict_drive(hbrk_pkg::op_e op,
                                           hbrk_pkg::speed_t tgt [hbrk_pkg::NUM_CH]);
    drive_t r;
    int d;
    int mag;
    int kd;
    int iv;
    bit moving;
    kd = int'(cfg_shadow.kick_duty);
    iv = (cfg_shadow.ramp_interval == '0) ? 1 : int'(cfg_shadow.ramp_interval);
    case (op)
      hbrk_pkg::OP_SET: begin
        motor_speed = tgt;
        ctrl_mode   = hbrk_pkg::MODE_IDLE;
        tick_count  = '0;
      end
      hbrk_pkg::OP_STOP: begin
        moving = 1'b0;
        foreach (motor_speed[ch]) if (motor_speed[ch] != 0) moving = 1'b1;
        tick_count = '0;
        if (!moving || ramp_all()) ctrl_mode = hbrk_pkg::MODE_IDLE;
        else ctrl_mode = hbrk_pkg::MODE_RAMP;
      end
      hbrk_pkg::OP_KICK: begin
        tick_count = '0;
        if (cfg_shadow.kick_time == '0) begin
          motor_speed = tgt;
          ctrl_mode   = hbrk_pkg::MODE_IDLE;
        end else begin
          held_target = tgt;
          foreach (tgt[ch])
            motor_speed[ch] = (tgt[ch] > 0) ? hbrk_pkg::speed_t'(kd) :
                              (tgt[ch] < 0) ? hbrk_pkg::speed_t'(-kd) :
                                              hbrk_pkg::speed_t'(0);
          ctrl_mode = hbrk_pkg::MODE_KICK;
        end
      end
      default: begin
        // tick: only a running ramp or kick counts time
        if (ctrl_mode == hbrk_pkg::MODE_RAMP) begin
          tick_count = tick_count + 1'b1;
          if (int'(tick_count) >= iv) begin
            tick_count = '0;
            if (ramp_all()) ctrl_mode = hbrk_pkg::MODE_IDLE;
          end
        end else if (ctrl_mode == hbrk_pkg::MODE_KICK) begin
          tick_count = tick_count + 1'b1;
          if (tick_count >= cfg_shadow.kick_time) begin
            tick_count  = '0;
            motor_speed = held_target;
            ctrl_mode   = hbrk_pkg::MODE_IDLE;
          end
        end
      end
    endcase
    // inversion, direction code and saturated duty
    for (int ch = 0; ch < hbrk_pkg::NUM_CH; ch++) begin
      d = motor_speed[ch];
      if (cfg_shadow.invert_mask[ch]) d = -d;
      if (d > 0) r.dir[ch] = hbrk_pkg::DIR_FWD;
      else if (d < 0) r.dir[ch] = hbrk_pkg::DIR_REV;
      else r.dir[ch] = hbrk_pkg::DIR_OFF;
      mag = (d < 0) ? -d : d;
      if (mag > DUTY_LIMIT) mag = DUTY_LIMIT;
      if (mag > 255) mag = 255;
      r.duty[ch] = 8'(mag);
    end
    r.busy = (ctrl_mode != hbrk_pkg::MODE_IDLE);
    return r;
  endfunction

  function automatic drive_t mk_drive(logic [hbrk_pkg::DIR_W-1:0] d0,
                                      logic [hbrk_pkg::DIR_W-1:0] d1,
                                      logic [hbrk_pkg::DIR_W-1:0] d2,
                                      logic [hbrk_pkg::DIR_W-1:0] d3,
                                      int u0, int u1, int u2, int u3, bit b);
    drive_t r;
    r.dir[0]  = d0;     r.dir[1]  = d1;     r.dir[2]  = d2;     r.dir[3]  = d3;
    r.duty[0] = 8'(u0); r.duty[1] = 8'(u1); r.duty[2] = 8'(u2); r.duty[3] = 8'(u3);
    r.busy    = b;
    return r;
  endfunction

  function automatic script_row_t cmd_row(hbrk_pkg::op_e op, int a, int b, int c, int d);
    script_row_t row;
    row.is_cfg  = 1'b0;
    row.reg_idx = '0;
    row.reg_val = '0;
    row.op      = op;
    row.sp[0]   = hbrk_pkg::speed_t'(a);
    row.sp[1]   = hbrk_pkg::speed_t'(b);
    row.sp[2]   = hbrk_pkg::speed_t'(c);
    row.sp[3]   = hbrk_pkg::speed_t'(d);
    row.typed   = 1'b0;
    row.want    = '0;
    return row;
  endfunction

  function automatic script_row_t chk_row(hbrk_pkg::op_e op, int a, int b, int c, int d,
                                          drive_t want);
    script_row_t row;
    row       = cmd_row(op, a, b, c, d);
    row.typed = 1'b1;
    row.want  = want;
    return row;
  endfunction

  function automatic script_row_t cfg_row(logic [hbrk_pkg::CFG_IDX_W-1:0] idx, int val);
    script_row_t row;
    row         = cmd_row(hbrk_pkg::OP_TICK, 0, 0, 0, 0);
    row.is_cfg  = 1'b1;
    row.reg_idx = idx;
    row.reg_val = hbrk_pkg::CFG_DATA_W'(val);
    return row;
  endfunction

  function automatic void check_field(string what, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      fail_count++;
    end
  endfunction

  // mix of extremes, small magnitudes and full-range values
  task automatic rand_speeds(output hbrk_pkg::speed_t sp [hbrk_pkg::NUM_CH]);
    for (int ch = 0; ch < hbrk_pkg::NUM_CH; ch++) begin
      case ($urandom_range(0, 7))
        0:       sp[ch] = hbrk_pkg::speed_t'(-256);
        1:       sp[ch] = hbrk_pkg::speed_t'(255);
        2:       sp[ch] = '0;
        3:       sp[ch] = hbrk_pkg::speed_t'($urandom_range(1, 30));
        4:       sp[ch] = -hbrk_pkg::speed_t'($urandom_range(1, 30));
        default: sp[ch] = hbrk_pkg::speed_t'($urandom_range(0, 511));
      endcase
    end
  endtask

  // drive one command transaction, record its expected drive on acceptance
  task automatic send_cmd(hbrk_pkg::op_e op, hbrk_pkg::speed_t sp [hbrk_pkg::NUM_CH],
                          bit typed, drive_t want);
    drive_t model;
    if (src_idle_en && $urandom_range(0, 5) == 0) begin
      cmd_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    cmd_bus.valid             <= 1'b1;
    cmd_bus.operation         <= op;
    cmd_bus.front_left_speed  <= sp[0];
    cmd_bus.front_right_speed <= sp[1];
    cmd_bus.back_left_speed   <= sp[2];
    cmd_bus.back_right_speed  <= sp[3];
    do @(posedge clk_i); while (!cmd_bus.ready);
    model = predict_drive(op, sp);
    pending_drive.push_back(typed ? want : model);
    items_sent++;
  endtask

  // wait for every outstanding result, then let the pipeline settle
  task automatic drain();
    cmd_bus.valid <= 1'b0;
    while (pending_drive.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [hbrk_pkg::CFG_IDX_W-1:0] idx,
                           logic [hbrk_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      hbrk_pkg::REG_RAMP_STEP:     cfg_shadow.ramp_step     = val[7:0];
      hbrk_pkg::REG_RAMP_INTERVAL: cfg_shadow.ramp_interval = val[hbrk_pkg::TICK_W-1:0];
      hbrk_pkg::REG_KICK_DUTY:     cfg_shadow.kick_duty     = val[7:0];
      hbrk_pkg::REG_KICK_TIME:     cfg_shadow.kick_time     = val[hbrk_pkg::TICK_W-1:0];
      hbrk_pkg::REG_INVERT_MASK:   cfg_shadow.invert_mask   = val[hbrk_pkg::NUM_CH-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(int step, int iv, int kd, int kt, int inv);
    drain();
    write_reg(hbrk_pkg::REG_RAMP_STEP,     hbrk_pkg::CFG_DATA_W'(step));
    write_reg(hbrk_pkg::REG_RAMP_INTERVAL, hbrk_pkg::CFG_DATA_W'(iv));
    write_reg(hbrk_pkg::REG_KICK_DUTY,     hbrk_pkg::CFG_DATA_W'(kd));
    write_reg(hbrk_pkg::REG_KICK_TIME,     hbrk_pkg::CFG_DATA_W'(kt));
    write_reg(hbrk_pkg::REG_INVERT_MASK,   hbrk_pkg::CFG_DATA_W'(inv));
  endtask

  // tick transactions, sometimes cut short once the motors are settled
  task automatic run_ticks(int unsigned n);
    hbrk_pkg::speed_t sp [hbrk_pkg::NUM_CH];
    for (int unsigned k = 0; k < n; k++) begin
      if (ctrl_mode == hbrk_pkg::MODE_IDLE && $urandom_range(0, 3) == 0) break;
      rand_speeds(sp);
      send_cmd(hbrk_pkg::OP_TICK, sp, 1'b0, '0);
    end
  endtask

  // mostly complete set/stop and kick sequences, some loose commands
  task automatic run_traffic(int unsigned count);
    hbrk_pkg::speed_t sp [hbrk_pkg::NUM_CH];
    int unsigned stop_at;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          rand_speeds(sp);
          send_cmd(hbrk_pkg::OP_SET, sp, 1'b0, '0);
          rand_speeds(sp);
          send_cmd(hbrk_pkg::OP_STOP, sp, 1'b0, '0);
          run_ticks($urandom_range(1, 40));
        end
        3, 4, 5: begin
          rand_speeds(sp);
          send_cmd(hbrk_pkg::OP_KICK, sp, 1'b0, '0);
          run_ticks($urandom_range(1, 12));
        end
        default: begin
          rand_speeds(sp);
          send_cmd(hbrk_pkg::op_e'($urandom_range(0, 3)), sp, 1'b0, '0);
        end
      endcase
    end
  endtask

  // result sink with random back-pressure bursts
  always @(posedge clk_i) begin
    if (rst_ni !== 1'b1) begin
      sink_hold = 0;
      res_bus.ready <= 1'b0;
    end else if (sink_hold != 0) begin
      sink_hold--;
      if (sink_hold == 0) res_bus.ready <= 1'b1;
    end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
      sink_hold = $urandom_range(1, 16);
      res_bus.ready <= 1'b0;
    end else begin
      res_bus.ready <= 1'b1;
    end
  end

  // compare each result transaction with the oldest expected drive
  always @(posedge clk_i) begin : result_check
    drive_t got;
    drive_t want;
    if (rst_ni === 1'b1 && res_bus.valid === 1'b1 && res_bus.ready === 1'b1) begin
      got.dir[0]  = res_bus.front_left_dir;
      got.dir[1]  = res_bus.front_right_dir;
      got.dir[2]  = res_bus.back_left_dir;
      got.dir[3]  = res_bus.back_right_dir;
      got.duty[0] = res_bus.front_left_duty;
      got.duty[1] = res_bus.front_right_duty;
      got.duty[2] = res_bus.back_left_duty;
      got.duty[3] = res_bus.back_right_duty;
      got.busy    = res_bus.busy_res;
      if (pending_drive.size() == 0) begin
        $display("%0t: result transaction with no expected drive, expected none, actual %h",
                 $time, got);
        fail_count++;
      end else begin
        want = pending_drive.pop_front();
        for (int ch = 0; ch < hbrk_pkg::NUM_CH; ch++) begin
          check_field($sformatf("channel %0d dir", ch), want.dir[ch], got.dir[ch]);
          check_field($sformatf("channel %0d duty", ch), want.duty[ch], got.duty[ch]);
        end
        check_field("busy", want.busy, got.busy);
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((cmd_bus.valid === 1'b1 && cmd_bus.ready === 1'b1) ||
        (res_bus.valid === 1'b1 && res_bus.ready === 1'b1))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    script_row_t      script [$];
    hbrk_pkg::speed_t sp [hbrk_pkg::NUM_CH];

    rst_ni                    <= 1'b0;
    cfg_we_i                  <= 1'b0;
    cfg_idx_i                 <= '0;
    cfg_data_i                <= '0;
    cmd_bus.valid             <= 1'b0;
    cmd_bus.operation         <= hbrk_pkg::OP_SET;
    cmd_bus.front_left_speed  <= '0;
    cmd_bus.front_right_speed <= '0;
    cmd_bus.back_left_speed   <= '0;
    cmd_bus.back_right_speed  <= '0;

    // directed script, reset register values first
    script.push_back(chk_row(hbrk_pkg::OP_TICK, 0, 0, 0, 0,
      mk_drive(hbrk_pkg::DIR_OFF, hbrk_pkg::DIR_OFF, hbrk_pkg::DIR_OFF, hbrk_pkg::DIR_OFF,
               0, 0, 0, 0, 1'b0)));
    script.push_back(chk_row(hbrk_pkg::OP_SET, 255, -256, 0, 1,
      mk_drive(hbrk_pkg::DIR_REV, hbrk_pkg::DIR_FWD, hbrk_pkg::DIR_OFF, hbrk_pkg::DIR_REV,
               255, 255, 0, 1, 1'b0)));
    script.push_back(cmd_row(hbrk_pkg::OP_STOP, 0, 0, 0, 0));
    script.push_back(cmd_row(hbrk_pkg::OP_TICK, 0, 0, 0, 0));
    // set cancels the running ramp
    script.push_back(chk_row(hbrk_pkg::OP_SET, -256, -256, -256, -256,
      mk_drive(hbrk_pkg::DIR_FWD, hbrk_pkg::DIR_FWD, hbrk_pkg::DIR_FWD, hbrk_pkg::DIR_FWD,
               255, 255, 255, 255, 1'b0)));
    script.push_back(cmd_row(hbrk_pkg::OP_KICK, 7, -3, 0, -256));
    script.push_back(cmd_row(hbrk_pkg::OP_TICK, 0, 0, 0, 0));
    // soft stop during a kick, then kick during the ramp
    script.push_back(cmd_row(hbrk_pkg::OP_STOP, 0, 0, 0, 0));
    script.push_back(cmd_row(hbrk_pkg::OP_KICK, -100, 50, 255, 0));
    script.push_back(chk_row(hbrk_pkg::OP_SET, 0, 0, 0, 0,
      mk_drive(hbrk_pkg::DIR_OFF, hbrk_pkg::DIR_OFF, hbrk_pkg::DIR_OFF, hbrk_pkg::DIR_OFF,
               0, 0, 0, 0, 1'b0)));
    // soft stop with everything already stopped, tick while idle
    script.push_back(chk_row(hbrk_pkg::OP_STOP, 0, 0, 0, 0,
      mk_drive(hbrk_pkg::DIR_OFF, hbrk_pkg::DIR_OFF, hbrk_pkg::DIR_OFF, hbrk_pkg::DIR_OFF,
               0, 0, 0, 0, 1'b0)));
    script.push_back(chk_row(hbrk_pkg::OP_TICK, 0, 0, 0, 0,
      mk_drive(hbrk_pkg::DIR_OFF, hbrk_pkg::DIR_OFF, hbrk_pkg::DIR_OFF, hbrk_pkg::DIR_OFF,
               0, 0, 0, 0, 1'b0)));
    // zero step and interval, zero kick time, full kick duty, no inversion
    script.push_back(cfg_row(hbrk_pkg::REG_RAMP_STEP, 0));
    script.push_back(cfg_row(hbrk_pkg::REG_RAMP_INTERVAL, 0));
    script.push_back(cfg_row(hbrk_pkg::REG_KICK_DUTY, 255));
    script.push_back(cfg_row(hbrk_pkg::REG_KICK_TIME, 0));
    script.push_back(cfg_row(hbrk_pkg::REG_INVERT_MASK, 0));
    script.push_back(chk_row(hbrk_pkg::OP_SET, 3, -2, 1, 0,
      mk_drive(hbrk_pkg::DIR_FWD, hbrk_pkg::DIR_REV, hbrk_pkg::DIR_FWD, hbrk_pkg::DIR_OFF,
               3, 2, 1, 0, 1'b0)));
    script.push_back(cmd_row(hbrk_pkg::OP_STOP, 0, 0, 0, 0));
    script.push_back(cmd_row(hbrk_pkg::OP_TICK, 0, 0, 0, 0));
    script.push_back(cmd_row(hbrk_pkg::OP_TICK, 0, 0, 0, 0));
    script.push_back(chk_row(hbrk_pkg::OP_KICK, 5, -5, 0, -256,
      mk_drive(hbrk_pkg::DIR_FWD, hbrk_pkg::DIR_REV, hbrk_pkg::DIR_OFF, hbrk_pkg::DIR_REV,
               5, 5, 0, 255, 1'b0)));
    // short kick held until the targets apply
    script.push_back(cfg_row(hbrk_pkg::REG_KICK_TIME, 2));
    script.push_back(cmd_row(hbrk_pkg::OP_KICK, 1, -1, 0, 255));
    script.push_back(cmd_row(hbrk_pkg::OP_TICK, 0, 0, 0, 0));
    script.push_back(cmd_row(hbrk_pkg::OP_TICK, 0, 0, 0, 0));
    // step of 255 stops every channel but -256 at once, partial inversion
    script.push_back(cfg_row(hbrk_pkg::REG_RAMP_STEP, 255));
    script.push_back(cfg_row(hbrk_pkg::REG_RAMP_INTERVAL, 1));
    script.push_back(cfg_row(hbrk_pkg::REG_INVERT_MASK, 5));
    script.push_back(cmd_row(hbrk_pkg::OP_SET, 255, -256, -1, 100));
    script.push_back(cmd_row(hbrk_pkg::OP_STOP, 0, 0, 0, 0));
    script.push_back(cmd_row(hbrk_pkg::OP_KICK, -256, 255, 1, -1));
    script.push_back(cmd_row(hbrk_pkg::OP_STOP, 0, 0, 0, 0));
    script.push_back(cmd_row(hbrk_pkg::OP_TICK, 0, 0, 0, 0));

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (script[k]) begin
      if (script[k].is_cfg) begin
        drain();
        write_reg(script[k].reg_idx, script[k].reg_val);
      end else begin
        send_cmd(script[k].op, script[k].sp, script[k].typed, script[k].want);
      end
    end

    // longest interval and kick time, counters run part way before a set
    apply_settings(10, 1023, 200, 1023, 4'ha);
    rand_speeds(sp);
    send_cmd(hbrk_pkg::OP_KICK, sp, 1'b0, '0);
    run_ticks(LONG_TICKS);
    rand_speeds(sp);
    send_cmd(hbrk_pkg::OP_SET, sp, 1'b0, '0);
    send_cmd(hbrk_pkg::OP_STOP, sp, 1'b0, '0);
    run_ticks(LONG_TICKS);

    // random phases, each under its own register setting
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: apply_settings(1, 1, 255, 1, 0);
        1: apply_settings(255, 2, 0, 0, 4'hf);
        2: apply_settings(0, 0, $urandom_range(0, 255), $urandom_range(1, 4),
                          $urandom_range(0, 15));
        default: apply_settings($urandom_range(0, 3) == 0 ? $urandom_range(1, 255) :
                                                             $urandom_range(5, 80),
                                $urandom_range(1, 6),
                                $urandom_range(0, 255),
                                $urandom_range(0, 8),
                                $urandom_range(0, 15));
      endcase
      if (ph == NUM_PHASES - 1) begin
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
      end else begin
        src_idle_en  = ($urandom_range(0, 3) != 0);
        sink_idle_en = ($urandom_range(0, 3) != 0);
      end
      run_traffic(PHASE_ITEMS);
    end

    drain();
    if (fail_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
